FILE: rtl/kds_pkg.sv
// shared types and constants for the key debounce scanner
// no dependencies; imported by every module of the block except kds_fifo
`timescale 1ns / 1ps

package kds_pkg;

    // width of the per-key masks and pin levels on the ports
    localparam int MASK_W     = 8;
    localparam int COUNT_W    = 16;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 16;

    // depth of the queue between front and back, and of the result queue
    localparam int CMD_DEPTH  = 2;
    localparam int RES_DEPTH  = 2;

    // register indexes of the configuration port
    localparam logic [CFG_ADDR_W-1:0] CFG_VALID_TIME   = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_FAULT_TIME   = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_LATCH_MODE   = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_ACTIVE_LEVEL = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] CFG_PRESENT      = 3'd4;

    // reset values of the registers
    localparam logic [COUNT_W-1:0] RST_VALID_TIME   = 16'd20;
    localparam logic [COUNT_W-1:0] RST_FAULT_TIME   = 16'd1000;
    localparam logic [MASK_W-1:0]  RST_LATCH_MODE   = 8'h00;
    localparam logic [MASK_W-1:0]  RST_ACTIVE_LEVEL = 8'h00;
    localparam logic [MASK_W-1:0]  RST_PRESENT      = 8'hFF;

    // per-key condition, one-hot
    typedef enum logic [2:0] {
        COND_INVALID = 3'b001,
        COND_VALID   = 3'b010,
        COND_FAULT   = 3'b100
    } t_cond;

    typedef struct packed {
        logic [COUNT_W-1:0] valid_time;
        logic [COUNT_W-1:0] fault_time;
        logic [MASK_W-1:0]  latch_mode_mask;
        logic [MASK_W-1:0]  active_level_mask;
        logic [MASK_W-1:0]  present_mask;
    } t_cfg;

endpackage

FILE: rtl/kds_fifo.sv
// small synchronous word queue with full and empty flags
// depends on nothing; used by the front and the back of the scanner
`timescale 1ns / 1ps

module kds_fifo #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_wr_en,
    input  logic [WIDTH-1:0] i_wr_data,
    output logic             o_full,
    input  logic             i_rd_en,
    output logic [WIDTH-1:0] o_rd_data,
    output logic             o_empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wr_ptr, n_wr_ptr;
    logic [PW-1:0]    r_rd_ptr, n_rd_ptr;
    logic [CW-1:0]    r_count,  n_count;
    logic             wr_go, rd_go;

    assign o_full    = (r_count == CW'(DEPTH));
    assign o_empty   = (r_count == '0);
    assign wr_go     = i_wr_en && !o_full;
    assign rd_go     = i_rd_en && !o_empty;
    assign o_rd_data = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (wr_go) begin
            n_wr_ptr = (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (rd_go) begin
            n_rd_ptr = (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (wr_go && !rd_go) begin
            n_count = r_count + 1'b1;
        end else if (rd_go && !wr_go) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_go) begin
            r_mem[r_wr_ptr] <= i_wr_data;
        end
    end

endmodule

FILE: rtl/kds_front.sv
// front of the scanner: takes scan words and classifies every key
// depends on kds_pkg and kds_fifo; feeds kds_back through a short queue
`timescale 1ns / 1ps

module kds_front
    import kds_pkg::*;
#(
    parameter int KEY_COUNT = 8
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_cfg                 i_cfg,
    input  logic                 push,
    output logic                 full,
    input  logic [MASK_W-1:0]    i_pin_levels,
    input  logic                 i_cmd_pop,
    output logic                 o_cmd_empty,
    output logic [KEY_COUNT-1:0] o_pressed,
    output logic [KEY_COUNT-1:0] o_absent,
    output logic [KEY_COUNT-1:0] o_latch
);

    localparam int CMD_W = 3 * KEY_COUNT;

    logic [KEY_COUNT-1:0] pressed, absent, latch;
    logic [CMD_W-1:0]     cmd_rd;

    // keys past the mask width read as pressed and absent, and momentary
    for (genvar k = 0; k < KEY_COUNT; k++) begin : g_key
        if (k < MASK_W) begin : g_mapped
            assign pressed[k] = (i_pin_levels[k] == i_cfg.active_level_mask[k]);
            assign absent[k]  = !i_cfg.present_mask[k];
            assign latch[k]   = i_cfg.latch_mode_mask[k];
        end else begin : g_unmapped
            assign pressed[k] = 1'b1;
            assign absent[k]  = 1'b1;
            assign latch[k]   = 1'b0;
        end
    end

    kds_fifo #(
        .WIDTH (CMD_W),
        .DEPTH (CMD_DEPTH)
    ) u_cmd_q (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (push),
        .i_wr_data ({pressed, absent, latch}),
        .o_full    (full),
        .i_rd_en   (i_cmd_pop),
        .o_rd_data (cmd_rd),
        .o_empty   (o_cmd_empty)
    );

    assign {o_pressed, o_absent, o_latch} = cmd_rd;

endmodule

FILE: rtl/kds_back.sv
// back of the scanner: per-key hold counters and conditions, result queue
// depends on kds_pkg and kds_fifo; takes classified words from kds_front
`timescale 1ns / 1ps

module kds_back
    import kds_pkg::*;
#(
    parameter int KEY_COUNT = 8
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_cfg                 i_cfg,
    input  logic                 i_cmd_empty,
    output logic                 o_cmd_pop,
    input  logic [KEY_COUNT-1:0] i_pressed,
    input  logic [KEY_COUNT-1:0] i_absent,
    input  logic [KEY_COUNT-1:0] i_latch,
    input  logic                 pop,
    output logic                 empty,
    output logic [MASK_W-1:0]    o_valid_mask,
    output logic [MASK_W-1:0]    o_fault_mask
);

    logic [COUNT_W-1:0] r_hold [KEY_COUNT];
    logic [COUNT_W-1:0] n_hold [KEY_COUNT];
    t_cond              r_cond [KEY_COUNT];
    t_cond              n_cond [KEY_COUNT];
    logic [MASK_W-1:0]  vmask, fmask;
    logic               res_full;
    logic               go;

    assign go        = !i_cmd_empty && !res_full;
    assign o_cmd_pop = go;

    for (genvar k = 0; k < KEY_COUNT; k++) begin : g_key
        always_comb begin
            logic toward_valid;
            logic toward_invalid;
            toward_valid   = (r_cond[k] == COND_INVALID) && i_pressed[k];
            toward_invalid = (r_cond[k] == COND_VALID) && !i_pressed[k];
            n_hold[k] = r_hold[k];
            n_cond[k] = r_cond[k];
            if (i_absent[k]) begin
                n_cond[k] = COND_FAULT;
            end else if (i_latch[k]) begin
                // toggle once the opposite level has been held long enough
                if (toward_valid || toward_invalid) begin
                    if (r_hold[k] < i_cfg.valid_time) begin
                        n_hold[k] = r_hold[k] + 16'd1;
                    end else begin
                        n_cond[k] = toward_valid ? COND_VALID : COND_INVALID;
                        n_hold[k] = '0;
                    end
                end
            end else if (i_pressed[k]) begin
                if (r_hold[k] < i_cfg.fault_time) begin
                    n_hold[k] = r_hold[k] + 16'd1;
                end else begin
                    n_cond[k] = COND_FAULT;
                end
            end else begin
                unique case (r_cond[k])
                    COND_FAULT: n_cond[k] = COND_INVALID;
                    default: begin
                        n_cond[k] = (r_hold[k] >= i_cfg.valid_time) ? COND_VALID
                                                                   : COND_INVALID;
                    end
                endcase
                n_hold[k] = '0;
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_hold[k] <= '0;
                r_cond[k] <= COND_INVALID;
            end else if (go) begin
                r_hold[k] <= n_hold[k];
                r_cond[k] <= n_cond[k];
            end
        end
    end

    for (genvar b = 0; b < MASK_W; b++) begin : g_out
        if (b < KEY_COUNT) begin : g_key_bit
            assign vmask[b] = (n_cond[b] == COND_VALID);
            assign fmask[b] = (n_cond[b] == COND_FAULT);
        end else begin : g_no_key
            assign vmask[b] = 1'b0;
            assign fmask[b] = 1'b0;
        end
    end

    kds_fifo #(
        .WIDTH (2 * MASK_W),
        .DEPTH (RES_DEPTH)
    ) u_res_q (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (go),
        .i_wr_data ({vmask, fmask}),
        .o_full    (res_full),
        .i_rd_en   (pop),
        .o_rd_data ({o_valid_mask, o_fault_mask}),
        .o_empty   (empty)
    );

endmodule

FILE: rtl/key_debounce_scanner.sv
// key debounce scanner, top level: config registers, front and back parts
// path: a scan word is registered in the front queue, its result in the result queue
// throughput: one word per cycle while the result queue has room, set by the per-key update in the back
// both queues hold two words, so either side may stall without stopping the other
// reset: synchronous, active low; queues empty, counters zero, keys invalid, registers
// back to their defaults; no clearing pass
`timescale 1ns / 1ps

module key_debounce_scanner
    import kds_pkg::*;
#(
    parameter int KEY_COUNT = 8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // config write port, no read-back
    input  logic                  i_cfg_we,
    input  logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    // scan word side
    input  logic                  push,
    output logic                  full,
    input  logic [MASK_W-1:0]     i_pin_levels,
    // result word side
    input  logic                  pop,
    output logic                  empty,
    output logic [MASK_W-1:0]     o_valid_mask,
    output logic [MASK_W-1:0]     o_fault_mask
);

    t_cfg                 r_cfg;
    logic                 cmd_empty;
    logic                 cmd_pop;
    logic [KEY_COUNT-1:0] cmd_pressed;
    logic [KEY_COUNT-1:0] cmd_absent;
    logic [KEY_COUNT-1:0] cmd_latch;

    // register file; writes to unknown indexes fall through and are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.valid_time        <= RST_VALID_TIME;
            r_cfg.fault_time        <= RST_FAULT_TIME;
            r_cfg.latch_mode_mask   <= RST_LATCH_MODE;
            r_cfg.active_level_mask <= RST_ACTIVE_LEVEL;
            r_cfg.present_mask      <= RST_PRESENT;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                CFG_VALID_TIME:   r_cfg.valid_time        <= i_cfg_wdata;
                CFG_FAULT_TIME:   r_cfg.fault_time        <= i_cfg_wdata;
                CFG_LATCH_MODE:   r_cfg.latch_mode_mask   <= i_cfg_wdata[MASK_W-1:0];
                CFG_ACTIVE_LEVEL: r_cfg.active_level_mask <= i_cfg_wdata[MASK_W-1:0];
                CFG_PRESENT:      r_cfg.present_mask      <= i_cfg_wdata[MASK_W-1:0];
                default: ;
            endcase
        end
    end

    // front: pressed / absent / latching per key, queued as one word
    kds_front #(
        .KEY_COUNT (KEY_COUNT)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .push         (push),
        .full         (full),
        .i_pin_levels (i_pin_levels),
        .i_cmd_pop    (cmd_pop),
        .o_cmd_empty  (cmd_empty),
        .o_pressed    (cmd_pressed),
        .o_absent     (cmd_absent),
        .o_latch      (cmd_latch)
    );

    // back: one tick of every key's counter and condition per word
    kds_back #(
        .KEY_COUNT (KEY_COUNT)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_cmd_empty  (cmd_empty),
        .o_cmd_pop    (cmd_pop),
        .i_pressed    (cmd_pressed),
        .i_absent     (cmd_absent),
        .i_latch      (cmd_latch),
        .pop          (pop),
        .empty        (empty),
        .o_valid_mask (o_valid_mask),
        .o_fault_mask (o_fault_mask)
    );

endmodule

FILE: rtl/kds_checker.sv
// port-level checks for the key debounce scanner
// depends on kds_pkg; bound to key_debounce_scanner at the end of this file
`timescale 1ns / 1ps

module kds_port_checker
    import kds_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              push,
    input logic              full,
    input logic              pop,
    input logic              empty,
    input logic [MASK_W-1:0] o_valid_mask,
    input logic [MASK_W-1:0] o_fault_mask
);

    // out of reset the result queue is empty and the scan queue is not full
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> empty && !full)
        else $error("queues not empty after reset");

    // a key is never valid and fault at once
    a_disjoint: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> ((o_valid_mask & o_fault_mask) == '0))
        else $error("key both valid and fault");

    // an accepted scan word reaches the result side
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push && !full) |=> ##1 !empty)
        else $error("result word missing after accepted scan word");

    // a waiting result word holds until taken
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> !empty && $stable(o_valid_mask) && $stable(o_fault_mask))
        else $error("waiting result word changed");

endmodule

bind key_debounce_scanner kds_port_checker u_kds_checker (.*);
